[design/cme_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants for the counter machine executor.
// No dependencies; every other design file refers to it by scoped names.
package cme_pkg;

   // Default sizes for the top-level parameters
   localparam int unsigned PROG_DEPTH_DEF = 1024;
   localparam int unsigned REG_COUNT_DEF  = 1024;
   localparam int unsigned REG_WIDTH_DEF  = 32;

   // Fixed field widths
   localparam int unsigned CMD_W      = 2;
   localparam int unsigned IDX_W      = 10;
   localparam int unsigned PC_W       = 11;
   localparam int unsigned STEP_W     = 32;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [STEP_W-1:0] DEFAULT_STEP_LIMIT = 32'd20000000;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RUN  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROGRAM_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_LIMIT     = 1'd1;

   typedef enum logic [1:0] {
      OP_INC  = 2'd0,
      OP_DEC  = 2'd1,
      OP_GOTO = 2'd2,
      OP_STOP = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      RS_STOP     = 2'd0,
      RS_PAST_END = 2'd1,
      RS_LIMIT    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_DECODE,
      ST_EXEC,
      ST_RUN_DONE,
      ST_READ_DATA
   } state_type;

   // One program word, laid out as op / n / k from high to low
   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] n;
      logic [IDX_W-1:0] k;
   } instr_type;

   typedef struct packed {
      logic wr_en;
      logic halt;
   } alu_flags_type;

endpackage

[design/cme_prog_store.sv]
`timescale 1ns / 1ps
// Program memory: one write port for loads, one registered read port for fetch.
// Depends on cme_pkg for the instruction word type.
module cme_prog_store #(
   parameter int unsigned PROG_DEPTH = cme_pkg::PROG_DEPTH_DEF,
   parameter int unsigned PA_W       = $clog2(PROG_DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [PA_W-1:0]     wr_addr,
   input  cme_pkg::instr_type  wr_data,
   input  logic                rd_en,
   input  logic [PA_W-1:0]     rd_addr,
   output cme_pkg::instr_type  rd_data
);

   cme_pkg::instr_type prog_mem [PROG_DEPTH];
   cme_pkg::instr_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         prog_mem[wr_addr] <= wr_data;
      end
      // hold the fetched word until the next fetch
      if (rd_en) begin
         rd_data_ff <= prog_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/cme_reg_file.sv]
`timescale 1ns / 1ps
// Machine register file with index folding, registered read and one write port.
// Depends on cme_pkg for the index width.
module cme_reg_file #(
   parameter int unsigned REG_COUNT = cme_pkg::REG_COUNT_DEF,
   parameter int unsigned REG_WIDTH = cme_pkg::REG_WIDTH_DEF,
   parameter int unsigned RI_W      = $clog2(REG_COUNT)
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [cme_pkg::IDX_W-1:0] rd_index,
   output logic [REG_WIDTH-1:0]      rd_data,
   input  logic                      wr_en,
   input  logic [REG_WIDTH-1:0]      wr_data,
   input  logic                      clear_en,
   input  logic [RI_W-1:0]           clear_addr
);

   logic [REG_WIDTH-1:0] reg_mem [REG_COUNT];
   logic [REG_WIDTH-1:0] rd_data_ff;
   logic [RI_W-1:0]      wr_idx_ff;
   logic [RI_W-1:0]      red_idx;

   // Fold the index into the file: compare and subtract the shifted count,
   // one step for each shift that still fits in the index field.
   always_comb begin
      logic [cme_pkg::IDX_W-1:0] red_x;
      red_x = rd_index;
      for (int i = cme_pkg::IDX_W - 1; i >= 0; i--) begin
         if ((REG_COUNT << i) < (32'd1 << cme_pkg::IDX_W)) begin
            if (red_x >= cme_pkg::IDX_W'(REG_COUNT << i)) begin
               red_x = red_x - cme_pkg::IDX_W'(REG_COUNT << i);
            end
         end
      end
      red_idx = RI_W'(red_x);
   end

   always_ff @(posedge clock) begin
      if (clear_en) begin
         reg_mem[clear_addr] <= '0;
      end else if (wr_en) begin
         reg_mem[wr_idx_ff] <= wr_data;
      end
      // the write-back goes to the register read last
      if (rd_en) begin
         rd_data_ff <= reg_mem[red_idx];
         wr_idx_ff  <= red_idx;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/cme_alu.sv]
`timescale 1ns / 1ps
// Shared execute unit: one saturating increment/decrement adder plus pc update.
// Depends on cme_pkg for the instruction and flag types.
module cme_alu #(
   parameter int unsigned REG_WIDTH = cme_pkg::REG_WIDTH_DEF
) (
   input  cme_pkg::instr_type         instr,
   input  logic [REG_WIDTH-1:0]       reg_value,
   input  logic [cme_pkg::PC_W-1:0]   pc,
   output logic [REG_WIDTH-1:0]       reg_next,
   output logic [cme_pkg::PC_W-1:0]   pc_next,
   output cme_pkg::alu_flags_type     flags
);

   logic                 is_zero;
   logic                 is_max;
   logic [REG_WIDTH-1:0] addend;

   assign is_zero = (reg_value == '0);
   assign is_max  = (reg_value == '1);
   // add one for inc, add all ones (minus one) for dec
   assign addend   = (instr.op == cme_pkg::OP_INC) ? REG_WIDTH'(1) : '1;
   assign reg_next = reg_value + addend;

   always_comb begin
      flags.wr_en = 1'b0;
      flags.halt  = 1'b0;
      pc_next     = pc;
      unique case (instr.op)
         cme_pkg::OP_INC: begin
            flags.wr_en = !is_max;
            pc_next     = pc + cme_pkg::PC_W'(1);
         end
         cme_pkg::OP_DEC: begin
            flags.wr_en = !is_zero;
            pc_next     = is_zero ? cme_pkg::PC_W'(instr.k) : pc + cme_pkg::PC_W'(1);
         end
         cme_pkg::OP_GOTO: begin
            pc_next = cme_pkg::PC_W'(instr.n);
         end
         cme_pkg::OP_STOP: begin
            flags.halt = 1'b1;
         end
      endcase
   end

endmodule

[design/counter_machine_executor.sv]
`timescale 1ns / 1ps
// Counter machine executor. A load item gives no result. A read item reads
// the register file, then loads the output register. A run item first clears
// the register file one entry per cycle, then executes each instruction in
// three steps: fetch from the program memory, read the register file, then
// the shared adder updates the register and pc. After reset the same
// clearing pass runs before the first item is taken. No new item is taken
// while a read or run is in progress; a finished result waits in the output
// register while the next item is taken.
// Depends on cme_pkg, cme_prog_store, cme_reg_file and cme_alu.
module counter_machine_executor #(
   parameter int unsigned PROG_DEPTH = cme_pkg::PROG_DEPTH_DEF,
   parameter int unsigned REG_COUNT  = cme_pkg::REG_COUNT_DEF,
   parameter int unsigned REG_WIDTH  = cme_pkg::REG_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration writes
   input  logic                           csr_wr_en,
   input  logic [cme_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cme_pkg::CSR_DATA_W-1:0] csr_wr_data,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [cme_pkg::CMD_W-1:0]      req_cmd,
   input  logic [cme_pkg::IDX_W-1:0]      req_slot,
   input  logic [1:0]                     req_opcode,
   input  logic [cme_pkg::IDX_W-1:0]      req_operand_n,
   input  logic [cme_pkg::IDX_W-1:0]      req_operand_k,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [cme_pkg::STATUS_W-1:0]   rsp_run_status,
   output logic [cme_pkg::STEP_W-1:0]     rsp_steps_taken,
   output logic [cme_pkg::PC_W-1:0]       rsp_final_pc,
   output logic [cme_pkg::VALUE_W-1:0]    rsp_read_value
);

   localparam int unsigned PA_W = $clog2(PROG_DEPTH);
   localparam int unsigned RI_W = $clog2(REG_COUNT);

   // configuration registers
   logic [cme_pkg::PC_W-1:0]   program_length_ff;
   logic [cme_pkg::STEP_W-1:0] step_limit_ff;

   // sequencer state
   cme_pkg::state_type         state_ff, state_in;
   logic [cme_pkg::PC_W-1:0]   pc_ff, pc_in;
   logic [cme_pkg::STEP_W-1:0] steps_ff, steps_in;
   logic [RI_W-1:0]            clr_idx_ff, clr_idx_in;
   logic                       run_pend_ff, run_pend_in;
   cme_pkg::status_type        status_ff, status_in;

   // output register
   logic                           rsp_valid_ff;
   logic [cme_pkg::STATUS_W-1:0]   rsp_run_status_ff;
   logic [cme_pkg::STEP_W-1:0]     rsp_steps_taken_ff;
   logic [cme_pkg::PC_W-1:0]       rsp_final_pc_ff;
   logic [cme_pkg::VALUE_W-1:0]    rsp_read_value_ff;

   // datapath wires
   logic [cme_pkg::PC_W-1:0]   len_eff;
   logic                       past_end;
   logic                       at_limit;
   logic                       clear_last;
   logic                       accept;
   logic                       out_free;
   logic                       load_out;
   logic                       prog_wr_en;
   logic                       prog_rd_en;
   logic                       reg_rd_en;
   logic                       reg_wr_en;
   logic                       clear_en;
   logic [cme_pkg::IDX_W-1:0]  reg_rd_index;
   cme_pkg::instr_type         load_word;
   cme_pkg::instr_type         instr;
   logic [REG_WIDTH-1:0]       reg_value;
   logic [REG_WIDTH-1:0]       reg_next;
   logic [cme_pkg::PC_W-1:0]   pc_next;
   cme_pkg::alu_flags_type     alu_flags;

   // a length beyond the program memory acts as its depth
   assign len_eff    = (32'(program_length_ff) > PROG_DEPTH) ? cme_pkg::PC_W'(PROG_DEPTH)
                                                              : program_length_ff;
   assign past_end   = (pc_ff >= len_eff);
   assign at_limit   = (steps_ff >= step_limit_ff);
   assign clear_last = (clr_idx_ff == RI_W'(REG_COUNT - 1));
   assign accept     = req_valid && (state_ff == cme_pkg::ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign load_word.op = cme_pkg::op_type'(req_opcode);
   assign load_word.n  = req_operand_n;
   assign load_word.k  = req_operand_k;

   cme_prog_store #(
      .PROG_DEPTH (PROG_DEPTH),
      .PA_W       (PA_W)
   ) u_prog_store (
      .clock   (clock),
      .wr_en   (prog_wr_en),
      .wr_addr (PA_W'(req_slot)),
      .wr_data (load_word),
      .rd_en   (prog_rd_en),
      .rd_addr (PA_W'(pc_ff)),
      .rd_data (instr)
   );

   cme_reg_file #(
      .REG_COUNT (REG_COUNT),
      .REG_WIDTH (REG_WIDTH),
      .RI_W      (RI_W)
   ) u_reg_file (
      .clock      (clock),
      .rd_en      (reg_rd_en),
      .rd_index   (reg_rd_index),
      .rd_data    (reg_value),
      .wr_en      (reg_wr_en),
      .wr_data    (reg_next),
      .clear_en   (clear_en),
      .clear_addr (clr_idx_ff)
   );

   cme_alu #(
      .REG_WIDTH (REG_WIDTH)
   ) u_alu (
      .instr     (instr),
      .reg_value (reg_value),
      .pc        (pc_ff),
      .reg_next  (reg_next),
      .pc_next   (pc_next),
      .flags     (alu_flags)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cme_pkg::ST_CLEAR: begin
            if (clear_last) begin
               state_in = run_pend_ff ? cme_pkg::ST_FETCH : cme_pkg::ST_IDLE;
            end
         end
         cme_pkg::ST_IDLE: begin
            if (accept && (req_cmd == cme_pkg::CMD_RUN)) begin
               state_in = cme_pkg::ST_CLEAR;
            end else if (accept && (req_cmd == cme_pkg::CMD_READ)) begin
               state_in = cme_pkg::ST_READ_DATA;
            end
         end
         cme_pkg::ST_FETCH: begin
            state_in = (past_end || at_limit) ? cme_pkg::ST_RUN_DONE : cme_pkg::ST_DECODE;
         end
         cme_pkg::ST_DECODE: begin
            state_in = cme_pkg::ST_EXEC;
         end
         cme_pkg::ST_EXEC: begin
            state_in = alu_flags.halt ? cme_pkg::ST_RUN_DONE : cme_pkg::ST_FETCH;
         end
         cme_pkg::ST_RUN_DONE, cme_pkg::ST_READ_DATA: begin
            if (out_free) begin
               state_in = cme_pkg::ST_IDLE;
            end
         end
      endcase
   end

   // outputs and datapath register updates
   always_comb begin
      req_stall    = (state_ff != cme_pkg::ST_IDLE);
      prog_wr_en   = accept && (req_cmd == cme_pkg::CMD_LOAD) && (32'(req_slot) < PROG_DEPTH);
      prog_rd_en   = (state_ff == cme_pkg::ST_FETCH);
      reg_rd_en    = (accept && (req_cmd == cme_pkg::CMD_READ))
                     || (state_ff == cme_pkg::ST_DECODE);
      reg_rd_index = (state_ff == cme_pkg::ST_DECODE) ? instr.n : req_slot;
      reg_wr_en    = (state_ff == cme_pkg::ST_EXEC) && alu_flags.wr_en;
      clear_en     = (state_ff == cme_pkg::ST_CLEAR);
      load_out     = ((state_ff == cme_pkg::ST_RUN_DONE) || (state_ff == cme_pkg::ST_READ_DATA))
                     && out_free;

      clr_idx_in  = clear_en ? clr_idx_ff + RI_W'(1) : '0;
      run_pend_in = run_pend_ff;
      pc_in       = pc_ff;
      steps_in    = steps_ff;
      status_in   = status_ff;

      if (accept && (req_cmd == cme_pkg::CMD_RUN)) begin
         run_pend_in = 1'b1;
         pc_in       = '0;
         steps_in    = '0;
      end
      if (clear_en && clear_last) begin
         run_pend_in = 1'b0;
      end
      if (state_ff == cme_pkg::ST_FETCH) begin
         // past the end wins over the step limit
         status_in = past_end ? cme_pkg::RS_PAST_END : cme_pkg::RS_LIMIT;
      end
      if (state_ff == cme_pkg::ST_EXEC) begin
         pc_in    = pc_next;
         steps_in = steps_ff + cme_pkg::STEP_W'(1);
         if (alu_flags.halt) begin
            status_in = cme_pkg::RS_STOP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= cme_pkg::ST_CLEAR;
         pc_ff       <= '0;
         steps_ff    <= '0;
         clr_idx_ff  <= '0;
         run_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pc_ff       <= pc_in;
         steps_ff    <= steps_in;
         clr_idx_ff  <= clr_idx_in;
         run_pend_ff <= run_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         program_length_ff <= '0;
         step_limit_ff     <= cme_pkg::DEFAULT_STEP_LIMIT;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            cme_pkg::CSR_PROGRAM_LENGTH: program_length_ff <= csr_wr_data[cme_pkg::PC_W-1:0];
            cme_pkg::CSR_STEP_LIMIT:     step_limit_ff     <= csr_wr_data;
         endcase
      end
   end

   // output register: a new result enters only when the old one has been transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         if (state_ff == cme_pkg::ST_RUN_DONE) begin
            rsp_run_status_ff  <= status_ff;
            rsp_steps_taken_ff <= steps_ff;
            rsp_final_pc_ff    <= pc_ff;
            rsp_read_value_ff  <= '0;
         end else begin
            rsp_run_status_ff  <= '0;
            rsp_steps_taken_ff <= '0;
            rsp_final_pc_ff    <= '0;
            rsp_read_value_ff  <= cme_pkg::VALUE_W'(reg_value);
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_run_status  = rsp_run_status_ff;
   assign rsp_steps_taken = rsp_steps_taken_ff;
   assign rsp_final_pc    = rsp_final_pc_ff;
   assign rsp_read_value  = rsp_read_value_ff;

   // an instruction only executes inside the program and under the step limit
   a_exec_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cme_pkg::ST_EXEC) |-> ((steps_ff < step_limit_ff) && (pc_ff < len_eff)))
      else $error("instruction executed outside program or past step limit");

   // a past-end report really has pc at or beyond the length
   a_past_end_status: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == cme_pkg::ST_RUN_DONE) && (status_ff == cme_pkg::RS_PAST_END))
      |-> (pc_ff >= len_eff))
      else $error("past-end status with pc inside program");

   // a fresh response only comes out of a finishing state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff))
      |-> ($past(state_ff == cme_pkg::ST_RUN_DONE) || $past(state_ff == cme_pkg::ST_READ_DATA)))
      else $error("response raised outside a finishing state");

   // the clearing pass does not stop short of the last entry
   a_clear_sweep: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == cme_pkg::ST_CLEAR) && !clear_last) |=> (state_ff == cme_pkg::ST_CLEAR))
      else $error("clearing pass left early");

endmodule
